FILE: design/qrs_pkg.sv
package qrs_pkg;

    // Root kind reported with each result beat.
    typedef enum logic [2:0] {
        KIND_INFINITE = 3'd0,
        KIND_NONE     = 3'd1,
        KIND_LINEAR   = 3'd2,
        KIND_TWO_REAL = 3'd3,
        KIND_DOUBLE   = 3'd4,
        KIND_COMPLEX  = 3'd5
    } root_kind_t;

    localparam int unsigned KIND_W = 3;

endpackage

FILE: design/qrs_sqrt_cell.sv
module qrs_sqrt_cell #(
    parameter int unsigned ROOT_W = 33,
    parameter int unsigned SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_rad,
    input  logic [ROOT_W-1:0]     in_root,
    input  logic [ROOT_W+1:0]     in_rem,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [2*ROOT_W-1:0]   out_rad,
    output logic [ROOT_W-1:0]     out_root,
    output logic [ROOT_W+1:0]     out_rem,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int unsigned RAD_W = 2 * ROOT_W;
    localparam int unsigned WORK_W = ROOT_W + 4;

    logic                valid_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [SIDE_W-1:0]   side_reg;

    logic [WORK_W-1:0]   rem_shift;
    logic [WORK_W-1:0]   trial;
    logic                take;
    logic [RAD_W-1:0]    rad_next;
    logic [ROOT_W-1:0]   root_next;
    logic [ROOT_W+1:0]   rem_next;
    logic [WORK_W-1:0]   rem_diff;

    // One root bit per cell: bring down the next two radicand bits and try 4r+1.
    always_comb
    begin
        rem_shift = {in_rem, in_rad[RAD_W-1 -: 2]};
        trial     = {2'b00, in_root, 2'b01};
        take      = (rem_shift >= trial);
        rem_diff  = rem_shift - trial;
        rem_next  = take ? rem_diff[ROOT_W+1:0] : rem_shift[ROOT_W+1:0];
        root_next = {in_root[ROOT_W-2:0], take};
        rad_next  = {in_rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;
    assign out_side  = side_reg;

endmodule

FILE: design/qrs_div_cell.sv
module qrs_div_cell #(
    parameter int unsigned QUO_W  = 50,
    parameter int unsigned DEN_W  = 33,
    parameter int unsigned SIDE_W = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [QUO_W-1:0]   in_num,
    input  logic [QUO_W-1:0]   in_quo,
    input  logic [DEN_W-1:0]   in_rem,
    input  logic [DEN_W-1:0]   in_den,
    input  logic [SIDE_W-1:0]  in_side,
    output logic               out_valid,
    output logic [QUO_W-1:0]   out_num,
    output logic [QUO_W-1:0]   out_quo,
    output logic [DEN_W-1:0]   out_rem,
    output logic [DEN_W-1:0]   out_den,
    output logic [SIDE_W-1:0]  out_side
);

    logic               valid_reg;
    logic [QUO_W-1:0]   num_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [SIDE_W-1:0]  side_reg;

    logic [DEN_W:0]     rem_shift;
    logic [DEN_W:0]     rem_diff;
    logic               take;
    logic [DEN_W-1:0]   rem_next;

    // Restoring division, one quotient bit per cell.
    always_comb
    begin
        rem_shift = {in_rem, in_num[QUO_W-1]};
        take      = (rem_shift >= {1'b0, in_den});
        rem_diff  = rem_shift - {1'b0, in_den};
        rem_next  = take ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= {in_num[QUO_W-2:0], 1'b0};
            quo_reg  <= {in_quo[QUO_W-2:0], take};
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_quo   = quo_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

FILE: design/quadratic_root_solver_core.sv
// Quadratic root solver: takes signed fixed-point coefficients a, b, c of
// a*x^2 + b*x + c = 0 and returns a root kind with two fixed-point results
// (two real roots, a double root, the real part and imaginary magnitude of a
// complex pair, or the single root of the linear case). It accepts one beat
// per cycle and delivers one result beat per input beat, in order. The
// pipeline runs through registers for signs and magnitudes, the split
// partial-product multiplies and the exact discriminant, then a square-root
// cell chain with one cell per root bit, a numerator selection register, two
// parallel divider cell chains with one cell per quotient bit, and saturation
// into the output register. When the output beat is not taken the whole
// pipeline holds.
module quadratic_root_solver_core #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // coef_quad, coef_lin, coef_const, zero fill
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // root_first, root_second, zero fill
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_tdata,
    // root_kind, saturated
    output logic [qrs_pkg::KIND_W:0]              m_tuser
);

    localparam int unsigned W     = DATA_WIDTH;
    localparam int unsigned F     = FRAC_BITS;
    localparam int unsigned H     = (W + 1) / 2;
    localparam int unsigned L     = W - H;
    localparam int unsigned PW    = 2 * W;
    localparam int unsigned DW    = PW + 2;
    localparam int unsigned SQ    = W + 1;
    localparam int unsigned NW    = W + 2;
    localparam int unsigned DENW  = W + 1;
    localparam int unsigned QW    = NW + F;
    localparam int unsigned KW    = qrs_pkg::KIND_W;
    localparam int unsigned SSW   = KW + 3 + 3 * W;
    localparam int unsigned OUT_W = ((2 * W + 7) / 8) * 8;

    logic en;

    // ---------------- stage 1: signs and magnitudes ----------------
    logic           v1_reg;
    logic           na1_reg, nb1_reg, nc1_reg;
    logic [W-1:0]   ma1_reg, mb1_reg, mc1_reg;
    logic [W-1:0]   ra, rb, rc;

    assign ra = s_tdata[W-1:0];
    assign rb = s_tdata[2*W-1:W];
    assign rc = s_tdata[3*W-1:2*W];

    // ---------------- stage 2: partial products ----------------
    logic           v2_reg;
    logic [SSW-1:0] side2_reg;
    logic [2*H-1:0] bb_ll_reg, ac_ll_reg;
    logic [H+L-1:0] bb_lh_reg, bb_hl_reg, ac_lh_reg, ac_hl_reg;
    logic [2*L-1:0] bb_hh_reg, ac_hh_reg;

    // ---------------- stage 3: full products ----------------
    logic           v3_reg;
    logic [SSW-1:0] side3_reg;
    logic [PW-1:0]  bb3_reg, ac3_reg;

    // ---------------- stage 4: discriminant and kind ----------------
    logic                 v4_reg;
    logic [SSW-1:0]       side4_reg;
    logic [DW-1:0]        dmag4_reg;
    logic [DW-1:0]        dmag_next;
    qrs_pkg::root_kind_t  kind_next;

    logic                 s_na, s_nb, s_nc;
    logic [W-1:0]         s_ma, s_mb, s_mc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na1_reg   <= ra[W-1];
            nb1_reg   <= rb[W-1];
            nc1_reg   <= rc[W-1];
            ma1_reg   <= ra[W-1] ? (~ra + 1'b1) : ra;
            mb1_reg   <= rb[W-1] ? (~rb + 1'b1) : rb;
            mc1_reg   <= rc[W-1] ? (~rc + 1'b1) : rc;

            side2_reg <= {qrs_pkg::KIND_NONE, na1_reg, nb1_reg, nc1_reg,
                          ma1_reg, mb1_reg, mc1_reg};
            bb_ll_reg <= mb1_reg[H-1:0] * mb1_reg[H-1:0];
            bb_lh_reg <= mb1_reg[H-1:0] * mb1_reg[W-1:H];
            bb_hl_reg <= mb1_reg[W-1:H] * mb1_reg[H-1:0];
            bb_hh_reg <= mb1_reg[W-1:H] * mb1_reg[W-1:H];
            ac_ll_reg <= ma1_reg[H-1:0] * mc1_reg[H-1:0];
            ac_lh_reg <= ma1_reg[H-1:0] * mc1_reg[W-1:H];
            ac_hl_reg <= ma1_reg[W-1:H] * mc1_reg[H-1:0];
            ac_hh_reg <= ma1_reg[W-1:H] * mc1_reg[W-1:H];

            side3_reg <= side2_reg;
            bb3_reg   <= PW'(bb_ll_reg) + (PW'(bb_lh_reg) << H) + (PW'(bb_hl_reg) << H)
                         + (PW'(bb_hh_reg) << (2 * H));
            ac3_reg   <= PW'(ac_ll_reg) + (PW'(ac_lh_reg) << H) + (PW'(ac_hl_reg) << H)
                         + (PW'(ac_hh_reg) << (2 * H));

            side4_reg <= {kind_next, side3_reg[SSW-KW-1:0]};
            dmag4_reg <= dmag_next;
        end
    end

    assign {s_na, s_nb, s_nc, s_ma, s_mb, s_mc} = side3_reg[SSW-KW-1:0];

    // The discriminant is b^2 - 4ac, kept as sign and magnitude.
    always_comb
    begin
        logic [DW-1:0] bbx;
        logic [DW-1:0] ac4;
        logic          pos;
        logic          zero;
        bbx  = {2'b00, bb3_reg};
        ac4  = {ac3_reg, 2'b00};
        pos  = 1'b0;
        zero = 1'b0;
        if (s_mc != '0 && (s_na ^ s_nc))
        begin
            dmag_next = bbx + ac4;
            pos       = 1'b1;
        end
        else if (bbx >= ac4)
        begin
            dmag_next = bbx - ac4;
            pos       = (bbx != ac4);
            zero      = (bbx == ac4);
        end
        else
        begin
            dmag_next = ac4 - bbx;
        end

        if (s_ma == '0)
        begin
            if (s_mb == '0)
            begin
                kind_next = (s_mc == '0) ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NONE;
            end
            else
            begin
                kind_next = qrs_pkg::KIND_LINEAR;
            end
        end
        else if (pos)
        begin
            kind_next = qrs_pkg::KIND_TWO_REAL;
        end
        else if (zero)
        begin
            kind_next = qrs_pkg::KIND_DOUBLE;
        end
        else
        begin
            kind_next = qrs_pkg::KIND_COMPLEX;
        end
    end

    // ---------------- square-root cell chain ----------------
    logic [SQ:0]        sq_valid;
    logic [DW-1:0]      sq_rad  [SQ+1];
    logic [SQ-1:0]      sq_root [SQ+1];
    logic [SQ+1:0]      sq_rem  [SQ+1];
    logic [SSW-1:0]     sq_side [SQ+1];

    assign sq_valid[0] = v4_reg;
    assign sq_rad[0]   = dmag4_reg;
    assign sq_root[0]  = '0;
    assign sq_rem[0]   = '0;
    assign sq_side[0]  = side4_reg;

    for (genvar i = 0; i < SQ; i++)
    begin : g_sqrt
        qrs_sqrt_cell #(
            .ROOT_W (SQ),
            .SIDE_W (SSW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[i]),
            .in_rad    (sq_rad[i]),
            .in_root   (sq_root[i]),
            .in_rem    (sq_rem[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_valid[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_root  (sq_root[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // ---------------- numerator selection ----------------
    qrs_pkg::root_kind_t  q_kind;
    logic                 q_na, q_nb, q_nc;
    logic [W-1:0]         q_ma, q_mb, q_mc;
    logic [SQ-1:0]        q_s;

    assign q_kind = qrs_pkg::root_kind_t'(sq_side[SQ][SSW-1 -: KW]);
    assign {q_na, q_nb, q_nc, q_ma, q_mb, q_mc} = sq_side[SQ][SSW-KW-1:0];
    assign q_s = sq_root[SQ];

    logic                 v5_reg;
    logic [QW-1:0]        num1_reg, num2_reg;
    logic [DENW-1:0]      den5_reg;
    logic [KW:0]          side5a_reg;
    logic                 side5b_reg;

    logic [NW-1:0]        n1_mag, n2_mag;
    logic                 n1_neg, n2_neg;
    logic [DENW-1:0]      den_sel;

    always_comb
    begin
        logic signed [NW:0] negvb;
        logic signed [NW:0] t1;
        logic signed [NW:0] t2;
        logic [NW:0]        a1;
        logic [NW:0]        a2;
        logic [NW:0]        av;
        negvb = q_nb ? $signed({2'b00, q_mb}) : -$signed({2'b00, q_mb});
        t1    = negvb + $signed({2'b00, q_s});
        t2    = negvb - $signed({2'b00, q_s});
        a1    = t1[NW] ? -t1 : t1;
        a2    = t2[NW] ? -t2 : t2;
        av    = negvb[NW] ? -negvb : negvb;
        n1_mag  = '0;
        n2_mag  = '0;
        n1_neg  = 1'b0;
        n2_neg  = 1'b0;
        den_sel = {q_ma, 1'b0};
        unique case (q_kind) inside
            qrs_pkg::KIND_TWO_REAL:
            begin
                n1_mag = a1[NW-1:0];
                n1_neg = t1[NW] ^ q_na;
                n2_mag = a2[NW-1:0];
                n2_neg = t2[NW] ^ q_na;
            end
            qrs_pkg::KIND_DOUBLE, qrs_pkg::KIND_COMPLEX:
            begin
                n1_mag = av[NW-1:0];
                n1_neg = negvb[NW] ^ q_na;
                if (q_kind == qrs_pkg::KIND_COMPLEX)
                begin
                    n2_mag = NW'(q_s);
                end
            end
            qrs_pkg::KIND_LINEAR:
            begin
                n1_mag  = NW'(q_mc);
                n1_neg  = ((q_mc != '0) && !q_nc) ^ q_nb;
                den_sel = DENW'(q_mb);
            end
            default:
            begin
                den_sel = DENW'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= sq_valid[SQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg   <= QW'(n1_mag) << F;
            num2_reg   <= QW'(n2_mag) << F;
            den5_reg   <= den_sel;
            side5a_reg <= {q_kind, n1_neg};
            side5b_reg <= n2_neg;
        end
    end

    // ---------------- divider cell chains ----------------
    logic [QW:0]        d1_valid, d2_valid;
    logic [QW-1:0]      d1_num [QW+1];
    logic [QW-1:0]      d1_quo [QW+1];
    logic [DENW-1:0]    d1_rem [QW+1];
    logic [DENW-1:0]    d1_den [QW+1];
    logic [KW:0]        d1_side [QW+1];
    logic [QW-1:0]      d2_num [QW+1];
    logic [QW-1:0]      d2_quo [QW+1];
    logic [DENW-1:0]    d2_rem [QW+1];
    logic [DENW-1:0]    d2_den [QW+1];
    logic               d2_side [QW+1];

    assign d1_valid[0] = v5_reg;
    assign d1_num[0]   = num1_reg;
    assign d1_quo[0]   = '0;
    assign d1_rem[0]   = '0;
    assign d1_den[0]   = den5_reg;
    assign d1_side[0]  = side5a_reg;
    assign d2_valid[0] = v5_reg;
    assign d2_num[0]   = num2_reg;
    assign d2_quo[0]   = '0;
    assign d2_rem[0]   = '0;
    assign d2_den[0]   = den5_reg;
    assign d2_side[0]  = side5b_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        qrs_div_cell #(
            .QUO_W  (QW),
            .DEN_W  (DENW),
            .SIDE_W (KW + 1)
        ) u_first (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d1_valid[j]),
            .in_num    (d1_num[j]),
            .in_quo    (d1_quo[j]),
            .in_rem    (d1_rem[j]),
            .in_den    (d1_den[j]),
            .in_side   (d1_side[j]),
            .out_valid (d1_valid[j+1]),
            .out_num   (d1_num[j+1]),
            .out_quo   (d1_quo[j+1]),
            .out_rem   (d1_rem[j+1]),
            .out_den   (d1_den[j+1]),
            .out_side  (d1_side[j+1])
        );

        qrs_div_cell #(
            .QUO_W  (QW),
            .DEN_W  (DENW),
            .SIDE_W (1)
        ) u_second (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d2_valid[j]),
            .in_num    (d2_num[j]),
            .in_quo    (d2_quo[j]),
            .in_rem    (d2_rem[j]),
            .in_den    (d2_den[j]),
            .in_side   (d2_side[j]),
            .out_valid (d2_valid[j+1]),
            .out_num   (d2_num[j+1]),
            .out_quo   (d2_quo[j+1]),
            .out_rem   (d2_rem[j+1]),
            .out_den   (d2_den[j+1]),
            .out_side  (d2_side[j+1])
        );
    end

    // ---------------- saturation and output register ----------------
    logic                 m_valid_reg;
    logic [W-1:0]         first_reg, second_reg;
    qrs_pkg::root_kind_t  kind_reg;
    logic                 sat_reg;

    logic [W-1:0]         r1_next, r2_next;
    logic                 sat1, sat2;

    always_comb
    begin
        logic [QW-1:0] lim1;
        logic [QW-1:0] lim2;
        logic [QW-1:0] v1;
        logic [QW-1:0] v2;
        lim1    = (QW'(1) << (W - 1)) - QW'(!d1_side[QW][0]);
        lim2    = (QW'(1) << (W - 1)) - QW'(!d2_side[QW]);
        sat1    = d1_quo[QW] > lim1;
        sat2    = d2_quo[QW] > lim2;
        v1      = sat1 ? lim1 : d1_quo[QW];
        v2      = sat2 ? lim2 : d2_quo[QW];
        r1_next = d1_side[QW][0] ? (~v1[W-1:0] + 1'b1) : v1[W-1:0];
        r2_next = d2_side[QW] ? (~v2[W-1:0] + 1'b1) : v2[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= d1_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            first_reg  <= r1_next;
            second_reg <= r2_next;
            kind_reg   <= qrs_pkg::root_kind_t'(d1_side[QW][KW:1]);
            sat_reg    <= sat1 | sat2;
        end
    end

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({second_reg, first_reg});
    assign m_tuser  = {sat_reg, kind_reg};

    // ---------------- assertions ----------------
    a_trivial_kinds_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[KW-1:0] == qrs_pkg::KIND_INFINITE
                     || m_tuser[KW-1:0] == qrs_pkg::KIND_NONE)
        |-> (m_tdata == '0) && !m_tuser[KW])
        else $error("infinite or no-root result carries nonzero data");

    a_single_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[KW-1:0] == qrs_pkg::KIND_DOUBLE
                     || m_tuser[KW-1:0] == qrs_pkg::KIND_LINEAR)
        |-> (m_tdata[2*W-1:W] == '0))
        else $error("second result not zero for a single-root kind");

    a_imag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[KW-1:0] == qrs_pkg::KIND_COMPLEX) |-> !m_tdata[2*W-1])
        else $error("imaginary magnitude is negative");

    a_stall_only_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output is free");

endmodule

FILE: dv/quadratic_root_solver_checker.sv
`timescale 1ns / 1ps

module quadratic_root_solver_checker #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_tdata,
    input  logic [qrs_pkg::KIND_W:0]              m_tuser,
    output int                                    fail_count,
    output int                                    pending_roots
);

    typedef struct packed {
        qrs_pkg::root_kind_t     kind;
        logic [DATA_WIDTH-1:0]   first;
        logic [DATA_WIDTH-1:0]   second;
        logic                    sat;
    } roots_t;

    roots_t expected_roots[$];
    int     fails = 0;

    // Signed quotient (num << FRAC_BITS) / den, truncated and clipped.
    function automatic logic [DATA_WIDTH-1:0] fixed_quotient(
        input logic signed [199:0] num, input logic signed [199:0] den, inout logic sat);
        logic signed [199:0] q;
        logic signed [199:0] hi_lim;
        logic signed [199:0] lo_lim;
        begin
            q = (num <<< FRAC_BITS) / den;
            hi_lim = (200'sd1 <<< (DATA_WIDTH - 1)) - 1;
            lo_lim = -(200'sd1 <<< (DATA_WIDTH - 1));
            if (q > hi_lim)
            begin
                q = hi_lim;
                sat = 1'b1;
            end
            else if (q < lo_lim)
            begin
                q = lo_lim;
                sat = 1'b1;
            end
            return q[DATA_WIDTH-1:0];
        end
    endfunction

    function automatic logic [199:0] floor_sqrt(input logic [199:0] v);
        logic [199:0] r;
        logic [199:0] t;
        begin
            r = 0;
            for (int b = 99; b >= 0; b--)
            begin
                t = r | (200'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        end
    endfunction

    function automatic roots_t solve_quadratic(input logic [3*DATA_WIDTH-1:0] coefs);
        logic signed [199:0] a;
        logic signed [199:0] b;
        logic signed [199:0] c;
        logic signed [199:0] disc;
        logic signed [199:0] s;
        roots_t r;
        begin
            a = $signed(coefs[DATA_WIDTH-1:0]);
            b = $signed(coefs[2*DATA_WIDTH-1:DATA_WIDTH]);
            c = $signed(coefs[3*DATA_WIDTH-1:2*DATA_WIDTH]);
            r = '0;
            if (a == 0)
            begin
                if (b == 0)
                    r.kind = (c == 0) ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NONE;
                else
                begin
                    r.kind = qrs_pkg::KIND_LINEAR;
                    r.first = fixed_quotient(-c, b, r.sat);
                end
            end
            else
            begin
                disc = b * b - 4 * a * c;
                if (disc > 0)
                begin
                    s = floor_sqrt(disc);
                    r.kind = qrs_pkg::KIND_TWO_REAL;
                    r.first = fixed_quotient(-b + s, 2 * a, r.sat);
                    r.second = fixed_quotient(-b - s, 2 * a, r.sat);
                end
                else if (disc == 0)
                begin
                    r.kind = qrs_pkg::KIND_DOUBLE;
                    r.first = fixed_quotient(-b, 2 * a, r.sat);
                end
                else
                begin
                    s = floor_sqrt(-disc);
                    r.kind = qrs_pkg::KIND_COMPLEX;
                    r.first = fixed_quotient(-b, 2 * a, r.sat);
                    r.second = fixed_quotient(s, (a < 0) ? -2 * a : 2 * a, r.sat);
                end
            end
            return r;
        end
    endfunction

    assign fail_count = fails;

    always @(posedge clk)
    begin
        roots_t want;
        roots_t got;
        if (s_tvalid && s_tready)
            expected_roots.push_back(solve_quadratic(s_tdata[3*DATA_WIDTH-1:0]));
        if (m_tvalid && m_tready)
        begin
            got.kind = qrs_pkg::root_kind_t'(m_tuser[qrs_pkg::KIND_W-1:0]);
            got.sat = m_tuser[qrs_pkg::KIND_W];
            got.first = m_tdata[DATA_WIDTH-1:0];
            got.second = m_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
            if (expected_roots.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual %h", $time, got);
                fails++;
            end
            else
            begin
                want = expected_roots.pop_front();
                if (got.kind !== want.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                    fails++;
                end
                if (got.first !== want.first)
                begin
                    $display("%0t: first expected %h actual %h", $time, want.first, got.first);
                    fails++;
                end
                if (got.second !== want.second)
                begin
                    $display("%0t: second expected %h actual %h", $time, want.second,
                             got.second);
                    fails++;
                end
                if (got.sat !== want.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
                    fails++;
                end
            end
        end
        pending_roots = expected_roots.size();
    end

endmodule

FILE: dv/tb_quadratic_root_solver_core.sv
`timescale 1ns / 1ps

module tb_quadratic_root_solver_core;

    localparam int unsigned DW = 32;
    localparam int unsigned LATENCY = 4 + (DW + 1) + 1 + (DW + 2 + 16) + 1;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [((3*DW+7)/8)*8-1:0]     s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [((2*DW+7)/8)*8-1:0]     m_tdata;
    logic [qrs_pkg::KIND_W:0]      m_tuser;
    int                            fail_count;
    int                            pending_roots;
    bit                            calm_phase;
    bit                            hold_receiver;
    bit                            stim_done;

    quadratic_root_solver_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    quadratic_root_solver_checker u_checker (
        .clk           (clk),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_roots (pending_roots)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom_range(0, 8) << 16;
            4: return -($urandom_range(0, 8) << 16);
            5: return $signed($urandom_range(0, 255)) - 128;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        while (!calm_phase && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
                m_tready <= 1'b0;
            else
                m_tready <= calm_phase || ($urandom_range(0, 99) >= 33);
        end
    end

    initial
    begin
        hold_receiver = 1'b0;
        wait (stim_done == 0 && rst_n);
        repeat (400) @(negedge clk);
        hold_receiver = 1'b1;
        repeat (300) @(negedge clk);
        hold_receiver = 1'b0;
    end

    initial
    begin
        logic [31:0] edge_vals[6];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        calm_phase = 1'b0;
        stim_done = 1'b0;
        edge_vals = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                      32'hFFFF_0000, 32'h0000_0001};
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // Degenerate, linear, double, complex and overflow cases.
        send_coefs(0, 0, 0);
        send_coefs(0, 0, 32'h0001_0000);
        send_coefs(0, 32'h0002_0000, 32'h0004_0000);
        send_coefs(0, 32'h0000_0001, 32'h7FFF_FFFF);
        send_coefs(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
        send_coefs(32'h0001_0000, 0, 32'h0001_0000);
        send_coefs(32'h0001_0000, 0, 32'hFFFF_0000);
        send_coefs(32'h0000_0001, 32'h7FFF_FFFF, 0);
        send_coefs(32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
        send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h0000_0001, 32'h0000_0003, 32'h0000_0002);
        for (int i = 0; i < 12; i++)
            send_coefs(edge_vals[$urandom_range(0, 5)], edge_vals[$urandom_range(0, 5)],
                       edge_vals[$urandom_range(0, 5)]);
        for (int i = 0; i < 1100; i++)
        begin
            calm_phase = (i >= 700 && i < 850);
            send_coefs(random_coef(), random_coef(), random_coef());
        end
        calm_phase = 1'b0;
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
        while (pending_roots != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
